/* rtl/core/deq_pkg.sv */
// ----------------------------------------------------------------------------
// deq_pkg: shared types and constants of the double-ended queue
// Opcodes, status codes, sequencer states and the result record.
// ----------------------------------------------------------------------------
package deq_pkg;

  localparam int unsigned OPCODE_W  = 3;
  localparam int unsigned DATA_W    = 32;
  localparam int unsigned STATUS_W  = 2;
  localparam int unsigned FILL_W    = 7;
  localparam int unsigned S_TDATA_W = 32;
  localparam int unsigned M_TDATA_W = 40;

  typedef enum logic [OPCODE_W-1:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_PEEK_FRONT = 3'd4,
    OP_CLEAR      = 3'd5,
    OP_PAIR_SWAP  = 3'd6,
    OP_DEDUP      = 3'd7
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_SW_B,
    S_SW_WA,
    S_SW_WB,
    S_DD_HEAD,
    S_DD_SCAN,
    S_FIN
  } state_e;

  typedef struct packed {
    logic [DATA_W-1:0] read_value;
    status_e           status;
    logic [FILL_W-1:0] fill_count;
    logic              is_empty;
  } res_t;

endpackage

/* rtl/core/deque_with_pair_swap_dedup.sv */
// ----------------------------------------------------------------------------
// deque_with_pair_swap_dedup: bounded double-ended queue of signed words
// Ring buffer in one RAM, with pair swap and adjacent duplicate removal.
// ----------------------------------------------------------------------------
// Usage:
//   The slave channel takes one request per handshake: s_axis_tuser holds
//   the opcode, s_axis_tdata the word to push. The master channel returns
//   exactly one result per request: s_axis_tuser-style status on
//   m_axis_tuser, read value, fill count and empty flag on m_axis_tdata.
//   One request is worked on at a time. Push, pop, peek and clear go
//   from acceptance to result through accept, then execute with the RAM
//   entry already prefetched. Pair swap on n >= 2 entries reads and
//   writes back one pair at a time, dedup scans the entries one by one;
//   both are bounded by the single read and single write port of the
//   entry RAM. With fewer than two entries they finish in the execute step.
//   The next request is accepted while a finished result still waits in the
//   output register; its result is held back until that register drains.
//   Reset empties the queue (front and count to zero) at once; the entry RAM
//   is not cleared, since entries are only used after being written.
//   When the receiver stalls, the result stays on m_axis_* unchanged.
// ----------------------------------------------------------------------------
module deque_with_pair_swap_dedup #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned WIDTH = 32
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [deq_pkg::S_TDATA_W-1:0]   s_axis_tdata,  // [31:0] push_value
  input  logic [deq_pkg::OPCODE_W-1:0]    s_axis_tuser,  // [2:0] opcode
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [deq_pkg::M_TDATA_W-1:0]   m_axis_tdata,  // [31:0] read_value,
                                                         // [38:32] fill_count,
                                                         // [39] is_empty
  output logic [deq_pkg::STATUS_W-1:0]    m_axis_tuser   // [1:0] status
);

  localparam int unsigned AW = $clog2(DEPTH);

  logic             ram_rd_en, ram_wr_en;
  logic [AW-1:0]    ram_rd_addr, ram_wr_addr;
  logic [WIDTH-1:0] ram_wr_data, ram_rd_data;

  logic             emit;
  logic             out_free;
  deq_pkg::res_t    res;
  deq_pkg::res_t    out_q;
  logic             out_valid_q;

  // Free when empty or draining this cycle.
  assign out_free = !out_valid_q || m_axis_tready;

  deq_ram #(
    .WIDTH (WIDTH),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i     (clk_i),
    .wr_en_i   (ram_wr_en),
    .wr_addr_i (ram_wr_addr),
    .wr_data_i (ram_wr_data),
    .rd_en_i   (ram_rd_en),
    .rd_addr_i (ram_rd_addr),
    .rd_data_o (ram_rd_data)
  );

  deq_ctrl #(
    .WIDTH (WIDTH),
    .DEPTH (DEPTH)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_valid_i     (s_axis_tvalid),
    .s_ready_o     (s_axis_tready),
    .s_opcode_i    (deq_pkg::op_e'(s_axis_tuser)),
    .s_push_i      (s_axis_tdata),
    .out_free_i    (out_free),
    .emit_o        (emit),
    .res_o         (res),
    .ram_rd_en_o   (ram_rd_en),
    .ram_rd_addr_o (ram_rd_addr),
    .ram_wr_en_o   (ram_wr_en),
    .ram_wr_addr_o (ram_wr_addr),
    .ram_wr_data_o (ram_wr_data),
    .ram_rd_data_i (ram_rd_data)
  );

  // Output register: load on emit, drop the valid once taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_q.is_empty, out_q.fill_count, out_q.read_value};
  assign m_axis_tuser  = out_q.status;

endmodule

/* rtl/core/deq_ram.sv */
// ----------------------------------------------------------------------------
// deq_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle; read data holds when idle.
// ----------------------------------------------------------------------------
module deq_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

/* rtl/core/deq_ctrl.sv */
// ----------------------------------------------------------------------------
// deq_ctrl: sequencer of the double-ended queue
// Holds front index and count, drives the entry RAM, runs swap and dedup walks.
// ----------------------------------------------------------------------------
module deq_ctrl #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_valid_i,
  output logic                         s_ready_o,
  input  deq_pkg::op_e                 s_opcode_i,
  input  logic [deq_pkg::DATA_W-1:0]   s_push_i,
  input  logic                         out_free_i,
  output logic                         emit_o,
  output deq_pkg::res_t                res_o,
  output logic                         ram_rd_en_o,
  output logic [$clog2(DEPTH)-1:0]     ram_rd_addr_o,
  output logic                         ram_wr_en_o,
  output logic [$clog2(DEPTH)-1:0]     ram_wr_addr_o,
  output logic [WIDTH-1:0]             ram_wr_data_o,
  input  logic [WIDTH-1:0]             ram_rd_data_i
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned DW = deq_pkg::DATA_W;
  localparam int unsigned FW = deq_pkg::FILL_W;

  deq_pkg::state_e  state_q, state_d;
  deq_pkg::op_e     op_q, op_d;
  logic [WIDTH-1:0] push_q, push_d;
  logic [AW-1:0]    front_q, front_d;
  logic [CW-1:0]    count_q, count_d;
  logic [CW-1:0]    idx_q, idx_d;
  logic [CW-1:0]    wpos_q, wpos_d;
  logic [WIDTH-1:0] tmp_q, tmp_d;
  logic [WIDTH-1:0] last_q, last_d;

  logic [WIDTH-1:0] push_word;
  logic [DW-1:0]    rd_ext;
  logic [FW-1:0]    fill_d;
  logic             accept;
  logic             cnt_zero, cnt_full, cnt_small;
  logic             swap_more, scan_more, dup_diff;
  logic [CW-1:0]    wpos_next;

  // Ring slot of logical position pos; front + pos stays below 2 * DEPTH.
  function automatic logic [AW-1:0] slot_f(input logic [AW-1:0] front,
                                           input logic [CW-1:0] pos);
    logic [CW:0] sum;
    sum = {{(CW + 1 - AW){1'b0}}, front} + {1'b0, pos};
    if (sum >= (CW + 1)'(DEPTH)) begin
      sum = sum - (CW + 1)'(DEPTH);
    end
    return sum[AW-1:0];
  endfunction

  // Width adaptation: keep low bits going narrower, sign-extend going wider.
  if (WIDTH > DW) begin : g_wide
    assign push_word = {{(WIDTH - DW){s_push_i[DW-1]}}, s_push_i};
    assign rd_ext    = ram_rd_data_i[DW-1:0];
  end else if (WIDTH == DW) begin : g_same
    assign push_word = s_push_i;
    assign rd_ext    = ram_rd_data_i;
  end else begin : g_narrow
    assign push_word = s_push_i[WIDTH-1:0];
    assign rd_ext    = {{(DW - WIDTH){ram_rd_data_i[WIDTH-1]}}, ram_rd_data_i};
  end

  if (CW > FW) begin : g_fill_cut
    assign fill_d = count_d[FW-1:0];
  end else if (CW == FW) begin : g_fill_same
    assign fill_d = count_d;
  end else begin : g_fill_ext
    assign fill_d = {{(FW - CW){1'b0}}, count_d};
  end

  assign s_ready_o = (state_q == deq_pkg::S_IDLE);
  assign accept    = s_valid_i && s_ready_o;
  assign cnt_zero  = (count_q == '0);
  assign cnt_full  = (count_q == CW'(DEPTH));
  assign cnt_small = (count_q < CW'(2));
  assign swap_more = (({1'b0, idx_q} + (CW + 1)'(3)) < {1'b0, count_q});
  assign scan_more = (({1'b0, idx_q} + (CW + 1)'(1)) < {1'b0, count_q});
  assign dup_diff  = (ram_rd_data_i != last_q);
  assign wpos_next = dup_diff ? (wpos_q + CW'(1)) : wpos_q;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      deq_pkg::S_IDLE: begin
        if (accept) state_d = deq_pkg::S_EXEC;
      end
      deq_pkg::S_EXEC: begin
        if ((op_q == deq_pkg::OP_PAIR_SWAP) && !cnt_small) begin
          state_d = deq_pkg::S_SW_B;
        end else if ((op_q == deq_pkg::OP_DEDUP) && !cnt_small) begin
          state_d = deq_pkg::S_DD_HEAD;
        end else if (out_free_i) begin
          state_d = deq_pkg::S_IDLE;
        end
      end
      deq_pkg::S_SW_B:    state_d = deq_pkg::S_SW_WA;
      deq_pkg::S_SW_WA:   state_d = deq_pkg::S_SW_WB;
      deq_pkg::S_SW_WB:   state_d = swap_more ? deq_pkg::S_SW_B : deq_pkg::S_FIN;
      deq_pkg::S_DD_HEAD: state_d = deq_pkg::S_DD_SCAN;
      deq_pkg::S_DD_SCAN: state_d = scan_more ? deq_pkg::S_DD_SCAN : deq_pkg::S_FIN;
      deq_pkg::S_FIN: begin
        if (out_free_i) state_d = deq_pkg::S_IDLE;
      end
      default:            state_d = deq_pkg::S_IDLE;
    endcase
  end

  // Outputs and datapath.
  always_comb begin
    op_d          = op_q;
    push_d        = push_q;
    front_d       = front_q;
    count_d       = count_q;
    idx_d         = idx_q;
    wpos_d        = wpos_q;
    tmp_d         = tmp_q;
    last_d        = last_q;
    ram_rd_en_o   = 1'b0;
    ram_rd_addr_o = front_q;
    ram_wr_en_o   = 1'b0;
    ram_wr_addr_o = front_q;
    ram_wr_data_o = push_q;
    emit_o        = 1'b0;
    res_o.read_value = '0;
    res_o.status     = deq_pkg::ST_OK;

    unique case (state_q)
      deq_pkg::S_IDLE: begin
        if (accept) begin
          // Prefetch the entry a pop or peek will return.
          op_d        = s_opcode_i;
          push_d      = push_word;
          idx_d       = '0;
          ram_rd_en_o = 1'b1;
          if (s_opcode_i == deq_pkg::OP_POP_BACK) begin
            ram_rd_addr_o = slot_f(front_q, count_q - CW'(1));
          end
        end
      end
      deq_pkg::S_EXEC: begin
        unique case (op_q)
          deq_pkg::OP_PUSH_FRONT, deq_pkg::OP_PUSH_BACK: begin
            if (out_free_i) begin
              emit_o = 1'b1;
              if (cnt_full) begin
                res_o.status = deq_pkg::ST_FULL;
              end else begin
                ram_wr_en_o = 1'b1;
                count_d     = count_q + CW'(1);
                if (op_q == deq_pkg::OP_PUSH_FRONT) begin
                  front_d = (front_q == '0) ? AW'(DEPTH - 1) : front_q - AW'(1);
                  ram_wr_addr_o = front_d;
                end else begin
                  ram_wr_addr_o = slot_f(front_q, count_q);
                end
              end
            end
          end
          deq_pkg::OP_POP_FRONT, deq_pkg::OP_POP_BACK, deq_pkg::OP_PEEK_FRONT: begin
            if (out_free_i) begin
              emit_o = 1'b1;
              if (cnt_zero) begin
                res_o.status = deq_pkg::ST_EMPTY;
              end else begin
                res_o.read_value = rd_ext;
                if (op_q == deq_pkg::OP_POP_FRONT) begin
                  count_d = count_q - CW'(1);
                  front_d = (front_q == AW'(DEPTH - 1)) ? '0 : front_q + AW'(1);
                end else if (op_q == deq_pkg::OP_POP_BACK) begin
                  count_d = count_q - CW'(1);
                end
              end
            end
          end
          deq_pkg::OP_CLEAR: begin
            if (out_free_i) begin
              emit_o  = 1'b1;
              count_d = '0;
            end
          end
          deq_pkg::OP_PAIR_SWAP, deq_pkg::OP_DEDUP: begin
            if (!cnt_small) begin
              // Start the walk at the front entry.
              ram_rd_en_o = 1'b1;
              if (op_q == deq_pkg::OP_DEDUP) begin
                idx_d  = CW'(1);
                wpos_d = '0;
              end
            end else if (out_free_i) begin
              emit_o = 1'b1;
            end
          end
          default: ;
        endcase
      end
      deq_pkg::S_SW_B: begin
        tmp_d         = ram_rd_data_i;
        ram_rd_en_o   = 1'b1;
        ram_rd_addr_o = slot_f(front_q, idx_q + CW'(1));
      end
      deq_pkg::S_SW_WA: begin
        ram_wr_en_o   = 1'b1;
        ram_wr_addr_o = slot_f(front_q, idx_q);
        ram_wr_data_o = ram_rd_data_i;
      end
      deq_pkg::S_SW_WB: begin
        ram_wr_en_o   = 1'b1;
        ram_wr_addr_o = slot_f(front_q, idx_q + CW'(1));
        ram_wr_data_o = tmp_q;
        idx_d         = idx_q + CW'(2);
        if (swap_more) begin
          ram_rd_en_o   = 1'b1;
          ram_rd_addr_o = slot_f(front_q, idx_q + CW'(2));
        end
      end
      deq_pkg::S_DD_HEAD: begin
        last_d        = ram_rd_data_i;
        ram_rd_en_o   = 1'b1;
        ram_rd_addr_o = slot_f(front_q, idx_q);
      end
      deq_pkg::S_DD_SCAN: begin
        // Writes land at or below the scan position, reads run ahead of it.
        wpos_d = wpos_next;
        if (dup_diff) begin
          ram_wr_en_o   = 1'b1;
          ram_wr_addr_o = slot_f(front_q, wpos_next);
          ram_wr_data_o = ram_rd_data_i;
          last_d        = ram_rd_data_i;
        end
        if (scan_more) begin
          ram_rd_en_o   = 1'b1;
          ram_rd_addr_o = slot_f(front_q, idx_q + CW'(1));
          idx_d         = idx_q + CW'(1);
        end else begin
          count_d = wpos_next + CW'(1);
        end
      end
      deq_pkg::S_FIN: begin
        emit_o = out_free_i;
      end
      default: ;
    endcase

    res_o.fill_count = fill_d;
    res_o.is_empty   = (count_d == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= deq_pkg::S_IDLE;
      front_q <= '0;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      front_q <= front_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q   <= op_d;
    push_q <= push_d;
    idx_q  <= idx_d;
    wpos_q <= wpos_d;
    tmp_q  <= tmp_d;
    last_q <= last_d;
  end

endmodule

/* rtl/core/deq_checker.sv */
// ----------------------------------------------------------------------------
// deq_checker: port-level checks of the double-ended queue
// Watches the result channel and checks consistency of the result fields.
// ----------------------------------------------------------------------------
module deq_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tready,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [deq_pkg::M_TDATA_W-1:0] m_axis_tdata,
  input logic [deq_pkg::STATUS_W-1:0]  m_axis_tuser
);

  // Hold a stalled result.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
                                        && $stable(m_axis_tuser))
    else $error("stalled result changed");

  // Empty flag tracks the fill count.
  a_empty_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[39] == (m_axis_tdata[38:32] == '0)))
    else $error("is_empty disagrees with fill_count");

  // A refused pop or peek returns zero on an empty queue.
  a_empty_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == deq_pkg::ST_EMPTY)
      |-> (m_axis_tdata[31:0] == '0) && m_axis_tdata[39])
    else $error("empty status with data or entries");

  // A refused push returns zero on a non-empty queue.
  a_full_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == deq_pkg::ST_FULL)
      |-> (m_axis_tdata[31:0] == '0) && !m_axis_tdata[39])
    else $error("full status with data or no entries");

  // Leave reset idle: no result pending and ready for a request.
  a_idle_after_reset: assert property (@(posedge clk_i)
    !rst_ni |=> !m_axis_tvalid && s_axis_tready)
    else $error("block not idle right after reset");

endmodule

bind deque_with_pair_swap_dedup deq_checker u_deq_checker (.*);

/* dv/tb_deque_with_pair_swap_dedup.sv */
// ----------------------------------------------------------------------------
// tb_deque_with_pair_swap_dedup: self-checking bench of the deque block
// Sends push, pop, peek, clear, pair swap and dedup requests over the slave
// stream, keeps its own ring-buffer copy of the queue to predict each result,
// and checks every result on the master stream field by field, in order.
// ----------------------------------------------------------------------------
module tb_deque_with_pair_swap_dedup;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned QDEPTH      = 64;
  localparam int unsigned RAND_ITEMS  = 1500;
  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int unsigned DRAIN_WAIT  = 100;   // longer than the slowest dedup
  localparam int unsigned MAX_PRINTS  = 100;

  typedef struct {
    deq_pkg::op_e op;
    logic [31:0]  value;
  } deque_req_t;

  // Shapes of the random traffic: grow, shrink, churn, or build duplicate runs.
  typedef enum int {
    PH_FILL,
    PH_DRAIN,
    PH_MIX,
    PH_DUP
  } phase_e;

  // --------------------------------------------------------------------------
  // DUT connections, all inputs known from time zero
  // --------------------------------------------------------------------------
  logic                          clk_i         = 1'b0;
  logic                          rst_ni        = 1'b0;
  logic                          s_axis_tvalid = 1'b0;
  logic                          s_axis_tready;
  logic [deq_pkg::S_TDATA_W-1:0] s_axis_tdata  = '0;  // [31:0] push_value
  logic [deq_pkg::OPCODE_W-1:0]  s_axis_tuser  = '0;  // [2:0] opcode
  logic                          m_axis_tvalid;
  logic                          m_axis_tready = 1'b0;
  logic [deq_pkg::M_TDATA_W-1:0] m_axis_tdata;        // [31:0] read_value,
                                                      // [38:32] fill_count,
                                                      // [39] is_empty
  logic [deq_pkg::STATUS_W-1:0]  m_axis_tuser;        // [1:0] status

  deque_with_pair_swap_dedup #(
    .DEPTH(QDEPTH),
    .WIDTH(32)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  // --------------------------------------------------------------------------
  // Bench state
  // --------------------------------------------------------------------------
  deque_req_t    queued_requests[$];    // requests not yet offered to the block
  deq_pkg::res_t predicted_results[$];  // results owed by the block, oldest first

  // Shadow copy of the queue contents
  logic [31:0] shadow_store [QDEPTH];
  logic [5:0]  shadow_front = '0;
  logic [6:0]  shadow_count = '0;

  bit          req_taken    = 1'b0;   // handshake seen at the last rising edge
  bit          res_taken    = 1'b0;
  bit          sink_hold    = 1'b0;   // long receiver stall in progress
  int unsigned src_wait     = 0;
  int unsigned sink_wait    = 0;
  int unsigned src_style    = 0;
  int unsigned sink_style   = 0;
  int unsigned error_count  = 0;
  int unsigned result_index = 0;
  int unsigned cycle_count  = 0;

  // --------------------------------------------------------------------------
  // Prediction: apply one request to the shadow queue, return its result
  // --------------------------------------------------------------------------
  function automatic deq_pkg::res_t deque_exec(deq_pkg::op_e op, logic [31:0] value);
    deq_pkg::res_t r;
    int            i;
    int            w;
    logic [31:0]   t;
    logic [5:0]    a;
    logic [5:0]    b;
    r.read_value = '0;
    r.status     = deq_pkg::ST_OK;
    case (op)
      deq_pkg::OP_PUSH_FRONT, deq_pkg::OP_PUSH_BACK: begin
        if (shadow_count >= QDEPTH) begin
          r.status = deq_pkg::ST_FULL;
        end else if (op == deq_pkg::OP_PUSH_FRONT) begin
          shadow_front               = shadow_front - 6'd1;
          shadow_store[shadow_front] = value;
          shadow_count               = shadow_count + 7'd1;
        end else begin
          shadow_store[shadow_front + shadow_count[5:0]] = value;
          shadow_count                                   = shadow_count + 7'd1;
        end
      end
      deq_pkg::OP_POP_FRONT, deq_pkg::OP_POP_BACK, deq_pkg::OP_PEEK_FRONT: begin
        if (shadow_count == 0) begin
          r.status = deq_pkg::ST_EMPTY;
        end else if (op == deq_pkg::OP_POP_BACK) begin
          shadow_count = shadow_count - 7'd1;
          r.read_value = shadow_store[shadow_front + shadow_count[5:0]];
        end else begin
          r.read_value = shadow_store[shadow_front];
          if (op == deq_pkg::OP_POP_FRONT) begin
            shadow_front = shadow_front + 6'd1;
            shadow_count = shadow_count - 7'd1;
          end
        end
      end
      deq_pkg::OP_CLEAR: begin
        shadow_count = '0;
      end
      deq_pkg::OP_PAIR_SWAP: begin
        // exchange logical positions 0/1, 2/3, ...; an odd tail stays put
        for (i = 0; i + 1 < int'(shadow_count); i += 2) begin
          a               = shadow_front + 6'(i);
          b               = shadow_front + 6'(i + 1);
          t               = shadow_store[a];
          shadow_store[a] = shadow_store[b];
          shadow_store[b] = t;
        end
      end
      default: begin
        // collapse runs of equal neighbors, back end follows the last survivor
        if (shadow_count > 1) begin
          w = 0;
          for (i = 1; i < int'(shadow_count); i++) begin
            t = shadow_store[shadow_front + 6'(i)];
            if (t != shadow_store[shadow_front + 6'(w)]) begin
              w++;
              shadow_store[shadow_front + 6'(w)] = t;
            end
          end
          shadow_count = 7'(w + 1);
        end
      end
    endcase
    r.fill_count = shadow_count;
    r.is_empty   = (shadow_count == 0);
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  task automatic add_req(deq_pkg::op_e op, logic [31:0] value);
    deque_req_t req;
    req.op    = op;
    req.value = value;
    queued_requests.push_back(req);
  endtask

  // Mostly wide random words; a small pool of extremes and small values makes
  // equal neighbors common enough for dedup to do real work.
  function automatic logic [31:0] pick_value(bit from_pool);
    if (!from_pool && $urandom_range(0, 3) != 0) return $urandom();
    case ($urandom_range(0, 5))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      2:       return 32'h8000_0000;
      3:       return 32'h7FFF_FFFF;
      default: return 32'($urandom_range(1, 3));
    endcase
  endfunction

  function automatic deq_pkg::op_e pick_op(phase_e kind);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r >= 90) return deq_pkg::op_e'($urandom_range(0, 7));
    case (kind)
      PH_FILL:  return (r < 80) ? (r[0] ? deq_pkg::OP_PUSH_FRONT : deq_pkg::OP_PUSH_BACK)
                                : deq_pkg::OP_PEEK_FRONT;
      PH_DRAIN: return (r < 80) ? (r[0] ? deq_pkg::OP_POP_FRONT : deq_pkg::OP_POP_BACK)
                                : deq_pkg::OP_PEEK_FRONT;
      PH_DUP: begin
        if (r < 60) return r[0] ? deq_pkg::OP_PUSH_FRONT : deq_pkg::OP_PUSH_BACK;
        return (r < 75) ? deq_pkg::OP_DEDUP : deq_pkg::OP_PAIR_SWAP;
      end
      default:  return deq_pkg::op_e'($urandom_range(0, 7));
    endcase
  endfunction

  // Idle length per item; style 0 gives stretches with no idling at all.
  function automatic int unsigned draw_gap(int unsigned style);
    case (style)
      0:       return 0;
      1:       return $urandom_range(0, 3);
      default: return $urandom_range(0, 18);
    endcase
  endfunction

  task automatic report_mismatch(string what, logic [39:0] got, logic [39:0] want);
    error_count++;
    if (error_count <= MAX_PRINTS)
      $display("mismatch on result %0d: %s got %0h want %0h",
               result_index, what, got, want);
  endtask

  // --------------------------------------------------------------------------
  // Clock, reset and run limit
  // --------------------------------------------------------------------------
  initial begin : clock_gen
    forever #10 clk_i = ~clk_i;
  end

  initial begin : reset_gen
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
  end

  always @(posedge clk_i) begin : watchdog
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Sampler: record handshakes at the rising edge, check results, then
  // predict the request taken at the same edge (its result comes later).
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin : sampler
    deq_pkg::res_t want;
    req_taken = rst_ni && s_axis_tvalid && s_axis_tready;
    res_taken = rst_ni && m_axis_tvalid && m_axis_tready;
    if (res_taken) begin
      if (predicted_results.size() == 0) begin
        report_mismatch("unexpected result", m_axis_tdata, '0);
      end else begin
        want = predicted_results.pop_front();
        if (m_axis_tdata[31:0] !== want.read_value)
          report_mismatch("read_value", 40'(m_axis_tdata[31:0]), 40'(want.read_value));
        if (m_axis_tuser !== want.status)
          report_mismatch("status", 40'(m_axis_tuser), 40'(want.status));
        if (m_axis_tdata[38:32] !== want.fill_count)
          report_mismatch("fill_count", 40'(m_axis_tdata[38:32]), 40'(want.fill_count));
        if (m_axis_tdata[39] !== want.is_empty)
          report_mismatch("is_empty", 40'(m_axis_tdata[39]), 40'(want.is_empty));
      end
      result_index++;
    end
    if (req_taken)
      predicted_results.push_back(deque_exec(deq_pkg::op_e'(s_axis_tuser), s_axis_tdata));
  end

  // --------------------------------------------------------------------------
  // Driver: hold a request until taken, then idle its drawn gap, then
  // offer the next one. One assignment per signal per falling edge.
  // --------------------------------------------------------------------------
  always @(negedge clk_i) begin : driver
    deque_req_t req;
    if (rst_ni && !(s_axis_tvalid && !req_taken)) begin
      if (src_wait > 0) begin
        s_axis_tvalid <= 1'b0;
        src_wait--;
      end else if (queued_requests.size() != 0) begin
        req = queued_requests.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= req.value;
        s_axis_tuser  <= req.op;
        if ($urandom_range(0, 39) == 0) src_style = $urandom_range(0, 2);
        src_wait = draw_gap(src_style);
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Receiver: after each result drop ready for a drawn number of cycles;
  // the long stall below overrides it.
  // --------------------------------------------------------------------------
  always @(negedge clk_i) begin : sink
    if (rst_ni) begin
      if (res_taken) begin
        if ($urandom_range(0, 39) == 0) sink_style = $urandom_range(0, 2);
        sink_wait = draw_gap(sink_style);
      end else if (sink_wait > 0) begin
        sink_wait--;
      end
      m_axis_tready <= (sink_wait == 0) && !sink_hold;
    end
  end

  // Hold the receiver off for a long stretch while the driver keeps offering,
  // so the output register fills and the block stalls its input.
  initial begin : long_stall
    @(posedge rst_ni);
    repeat (4000) @(negedge clk_i);
    sink_hold <= 1'b1;
    repeat (600) @(negedge clk_i);
    sink_hold <= 1'b0;
  end

  // --------------------------------------------------------------------------
  // Stimulus and end of run
  // --------------------------------------------------------------------------
  initial begin : main
    int unsigned  n;
    int unsigned  len;
    int unsigned  k;
    phase_e       kind;
    deq_pkg::op_e op;

    // Directed: word extremes at both ends, peek, swap on an even count
    add_req(deq_pkg::OP_PUSH_BACK,  32'h7FFF_FFFF);
    add_req(deq_pkg::OP_PUSH_FRONT, 32'h8000_0000);
    add_req(deq_pkg::OP_PUSH_BACK,  32'h0000_0000);
    add_req(deq_pkg::OP_PUSH_FRONT, 32'hFFFF_FFFF);
    add_req(deq_pkg::OP_PEEK_FRONT, $urandom());
    add_req(deq_pkg::OP_PAIR_SWAP,  $urandom());
    add_req(deq_pkg::OP_POP_FRONT,  $urandom());
    add_req(deq_pkg::OP_POP_BACK,   $urandom());
    // Dedup over runs of equal words, then swap with an odd tail
    add_req(deq_pkg::OP_CLEAR,      $urandom());
    add_req(deq_pkg::OP_PUSH_BACK,  32'd5);
    add_req(deq_pkg::OP_PUSH_BACK,  32'd5);
    add_req(deq_pkg::OP_PUSH_BACK,  32'd5);
    add_req(deq_pkg::OP_PUSH_BACK,  32'hFFFF_FFF9);
    add_req(deq_pkg::OP_PUSH_BACK,  32'hFFFF_FFF9);
    add_req(deq_pkg::OP_PUSH_BACK,  32'd5);
    add_req(deq_pkg::OP_DEDUP,      $urandom());
    add_req(deq_pkg::OP_PAIR_SWAP,  $urandom());
    add_req(deq_pkg::OP_POP_FRONT,  $urandom());
    add_req(deq_pkg::OP_POP_BACK,   $urandom());
    add_req(deq_pkg::OP_POP_FRONT,  $urandom());
    // Empty queue: refused pops and peek, harmless clear, swap and dedup
    add_req(deq_pkg::OP_POP_FRONT,  $urandom());
    add_req(deq_pkg::OP_POP_BACK,   $urandom());
    add_req(deq_pkg::OP_PEEK_FRONT, $urandom());
    add_req(deq_pkg::OP_CLEAR,      $urandom());
    add_req(deq_pkg::OP_PAIR_SWAP,  $urandom());
    add_req(deq_pkg::OP_DEDUP,      $urandom());

    // Random: start by filling past the top so pushes get refused as full
    n = 0;
    for (k = 0; k < 70; k++) begin
      add_req($urandom_range(0, 1) ? deq_pkg::OP_PUSH_FRONT : deq_pkg::OP_PUSH_BACK,
              pick_value(1'b0));
      n++;
    end
    while (n < RAND_ITEMS) begin
      kind = phase_e'($urandom_range(0, 3));
      len  = $urandom_range(8, 90);
      for (k = 0; k < len && n < RAND_ITEMS; k++) begin
        op = pick_op(kind);
        if (op == deq_pkg::OP_PUSH_FRONT || op == deq_pkg::OP_PUSH_BACK)
          add_req(op, pick_value(kind == PH_DUP));
        else
          add_req(op, $urandom());
        n++;
      end
    end

    // Wait for every request to be taken and every result to arrive
    @(posedge rst_ni);
    while (queued_requests.size() != 0 || s_axis_tvalid || predicted_results.size() != 0)
      @(negedge clk_i);
    repeat (DRAIN_WAIT) @(negedge clk_i);

    if (predicted_results.size() != 0)
      report_mismatch("missing results", 40'(predicted_results.size()), '0);

    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/core/deq_pkg.sv
rtl/core/deq_ram.sv
rtl/core/deq_ctrl.sv
rtl/core/deque_with_pair_swap_dedup.sv
rtl/core/deq_checker.sv
dv/tb_deque_with_pair_swap_dedup.sv
